@@ hw/rtl/sba_pkg.sv @@
// ----------------------------------------------------------------------------
// sba_pkg
// Shared widths, register indexes, types and the divider step function for
// the sub-frame byte averager.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int MAX_FRAME_BYTES = 65536;
  localparam int MAX_SUBFRAMES   = 256;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 16;                 // byte position within a sub-frame
  localparam int SUB_W      = 8;                  // sub-frame index
  localparam int SUM_W      = 16;                 // per-position sum
  localparam int DIVIDEND_W = SUM_W + 1;          // sum plus rounding offset
  localparam int COUNT_W    = 9;                  // frame_count register
  localparam int BYTES_W    = 17;                 // frame_bytes register
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  // Quotient is always below 256; resolve it two bits per stage.
  localparam int Q_W            = 8;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;
  localparam int SHIFT_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(1);
  localparam logic [BYTES_W-1:0] FRAME_BYTES_RESET = BYTES_W'(MAX_FRAME_BYTES);

  typedef struct packed {
    logic valid;
    logic done;
  } div_tag_t;

  typedef struct packed {
    logic                  qbit;
    logic [DIVIDEND_W-1:0] rem;
  } div_step_t;

  // One restoring step: try to take divisor << sh out of the remainder.
  function automatic div_step_t div_step(input logic [DIVIDEND_W-1:0] rem,
                                         input logic [COUNT_W-1:0]    divisor,
                                         input logic [SHIFT_W-1:0]    sh);
    logic [DIVIDEND_W-1:0] trial;
    div_step_t             res;
    trial = DIVIDEND_W'(divisor) << sh;
    if (rem >= trial) begin
      res.qbit = 1'b1;
      res.rem  = rem - trial;
    end else begin
      res.qbit = 1'b0;
      res.rem  = rem;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/subframe_byte_averager_unit.sv @@
// ----------------------------------------------------------------------------
// subframe_byte_averager_unit
// Rounded temporal average of frame_count byte sub-frames into one frame.
// ----------------------------------------------------------------------------
// Input channel: sample_valid / sample_stall carry one sample_byte per item,
// in position order, one sub-frame after another. An item is taken when
// sample_valid is high and sample_stall is low.
// Output channel: mean_valid / mean_stall carry mean_byte and frame_done.
// Only items of the last sub-frame produce a result; frame_done marks the
// final byte of the averaged frame.
// Config: cfg_valid / cfg_ready (always ready), cfg_index 0 = frame_count,
// 1 = frame_bytes. A write to either restarts the frame. Write only while
// the block is idle.
// Throughput: one item per cycle unless mean_stall freezes the pipeline.
// Steps: sum read, sum update, rounding add, four divider stages, output reg.
// The per-position sum lives in a 65536 x 16 RAM with one read and one
// write port; a sum still in flight is forwarded to the next item.
// Reset: frame_count = 1, frame_bytes = 65536, counters zero, pipeline
// empty. The sum RAM needs no clearing since the first sub-frame writes it.
// When mean_stall holds a waiting result the whole pipeline freezes and
// sample_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module subframe_byte_averager_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [sba_pkg::BYTE_W-1:0]      sample_byte,
  output logic                            mean_valid,
  input  logic                            mean_stall,
  output logic [sba_pkg::BYTE_W-1:0]      mean_byte,
  output logic                            frame_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sba_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [sba_pkg::COUNT_W-1:0] frame_count;
  logic [sba_pkg::BYTES_W-1:0] frame_bytes;
  logic [sba_pkg::POS_W-1:0]   byte_pos;
  logic [sba_pkg::SUB_W-1:0]   sub_idx;

  logic [sba_pkg::COUNT_W-1:0] count_eff;
  logic [sba_pkg::SUB_W-1:0]   count_last;
  logic [sba_pkg::POS_W-1:0]   bytes_last;
  logic [sba_pkg::SUB_W-1:0]   half_count;

  logic adv;
  logic accept;
  logic cfg_write;
  logic at_last_byte;

  // stage 1: RAM read in flight
  logic                       s1_valid;
  logic [sba_pkg::BYTE_W-1:0] s1_sample;
  logic [sba_pkg::POS_W-1:0]  s1_pos;
  logic                       s1_first;
  logic                       s1_last;
  logic                       s1_done;
  logic [sba_pkg::SUM_W-1:0]  rd_data;

  // stage 2: updated sum
  logic                       s2_valid;
  logic [sba_pkg::POS_W-1:0]  s2_pos;
  logic                       s2_last;
  logic                       s2_done;
  logic [sba_pkg::SUM_W-1:0]  s2_sum;

  logic [sba_pkg::SUM_W-1:0]      sum_base;
  logic [sba_pkg::SUM_W-1:0]      sum_next;
  logic [sba_pkg::DIVIDEND_W-1:0] dividend;
  sba_pkg::div_tag_t              div_in_tag;
  sba_pkg::div_tag_t              div_out_tag;
  logic [sba_pkg::Q_W-1:0]        div_quotient;

  logic [sba_pkg::SUM_W-1:0] sum_mem [sba_pkg::MAX_FRAME_BYTES];

  assign cfg_ready    = 1'b1;
  assign cfg_write    = cfg_valid && cfg_ready;
  assign adv          = !(mean_valid && mean_stall);
  assign sample_stall = !adv;
  assign accept       = sample_valid && adv;

  // clamp the registers into their working ranges
  always_comb begin
    if (frame_count == '0) begin
      count_eff = sba_pkg::COUNT_W'(1);
    end else if (frame_count > sba_pkg::COUNT_W'(sba_pkg::MAX_SUBFRAMES)) begin
      count_eff = sba_pkg::COUNT_W'(sba_pkg::MAX_SUBFRAMES);
    end else begin
      count_eff = frame_count;
    end
    count_last = sba_pkg::SUB_W'(count_eff - sba_pkg::COUNT_W'(1));
    half_count = count_eff[sba_pkg::COUNT_W-1:1];
    if (frame_bytes == '0) begin
      bytes_last = '0;
    end else if (frame_bytes > sba_pkg::BYTES_W'(sba_pkg::MAX_FRAME_BYTES)) begin
      bytes_last = sba_pkg::POS_W'(sba_pkg::MAX_FRAME_BYTES - 1);
    end else begin
      bytes_last = sba_pkg::POS_W'(frame_bytes - sba_pkg::BYTES_W'(1));
    end
  end

  assign at_last_byte = (byte_pos == bytes_last);

  // config registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= sba_pkg::FRAME_COUNT_RESET;
      frame_bytes <= sba_pkg::FRAME_BYTES_RESET;
      byte_pos    <= '0;
      sub_idx     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sba_pkg::REG_FRAME_COUNT: begin
          frame_count <= cfg_data[sba_pkg::COUNT_W-1:0];
          byte_pos    <= '0;
          sub_idx     <= '0;
        end
        sba_pkg::REG_FRAME_BYTES: begin
          frame_bytes <= cfg_data[sba_pkg::BYTES_W-1:0];
          byte_pos    <= '0;
          sub_idx     <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (at_last_byte) begin
        byte_pos <= '0;
        sub_idx  <= (sub_idx == count_last) ? '0 : sub_idx + sba_pkg::SUB_W'(1);
      end else begin
        byte_pos <= byte_pos + sba_pkg::POS_W'(1);
      end
    end
  end

  // forward the sum one stage ahead when it targets the same position
  always_comb begin
    if (s1_first) begin
      sum_base = '0;
    end else if (s2_valid && (s2_pos == s1_pos)) begin
      sum_base = s2_sum;
    end else begin
      sum_base = rd_data;
    end
    sum_next = sum_base + sba_pkg::SUM_W'(s1_sample);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data <= sum_mem[byte_pos];
      if (s1_valid) begin
        sum_mem[s1_pos] <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= sample_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample <= sample_byte;
      s1_pos    <= byte_pos;
      s1_first  <= (sub_idx == '0);
      s1_last   <= (sub_idx == count_last);
      s1_done   <= at_last_byte;
      s2_pos    <= s1_pos;
      s2_last   <= s1_last;
      s2_done   <= s1_done;
      s2_sum    <= sum_next;
    end
  end

  assign dividend         = sba_pkg::DIVIDEND_W'(s2_sum) + sba_pkg::DIVIDEND_W'(half_count);
  assign div_in_tag.valid = s2_valid && s2_last;
  assign div_in_tag.done  = s2_done;

  sba_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_tag   (div_in_tag),
    .dividend (dividend),
    .divisor  (count_eff),
    .out_tag  (div_out_tag),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (adv) begin
      mean_valid <= div_out_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mean_byte  <= div_quotient;
      frame_done <= div_out_tag.done;
    end
  end

  // position and sub-frame counters stay inside the configured frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= bytes_last)
    else $error("byte position beyond configured frame size");

  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    sub_idx <= count_last)
    else $error("sub-frame index beyond configured count");

  // a first sub-frame sum is the sample itself, never a stale RAM value
  a_first_sum: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1_first) |=> (s2_sum == sba_pkg::SUM_W'($past(s1_sample))))
    else $error("first sub-frame sum picked up an old value");

  // a frozen pipeline takes no new item
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (mean_valid && mean_stall) |=> $stable(byte_pos) && $stable(s2_sum))
    else $error("pipeline moved while the output was stalled");

endmodule

@@ hw/rtl/sba_divider.sv @@
// ----------------------------------------------------------------------------
// sba_divider
// Pipelined restoring divider: 17-bit dividend by a 9-bit count, 8-bit
// quotient, two quotient bits per stage, frozen as a whole by the enable.
// ----------------------------------------------------------------------------
module sba_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  sba_pkg::div_tag_t               in_tag,
  input  logic [sba_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [sba_pkg::COUNT_W-1:0]     divisor,
  output sba_pkg::div_tag_t               out_tag,
  output logic [sba_pkg::Q_W-1:0]         quotient
);

  sba_pkg::div_tag_t               tag      [sba_pkg::DIV_STAGES];
  logic [sba_pkg::DIVIDEND_W-1:0]  rem      [sba_pkg::DIV_STAGES];
  logic [sba_pkg::Q_W-1:0]         quo      [sba_pkg::DIV_STAGES];
  logic [sba_pkg::DIVIDEND_W-1:0]  rem_next [sba_pkg::DIV_STAGES];
  logic [sba_pkg::Q_W-1:0]         quo_next [sba_pkg::DIV_STAGES];

  always_comb begin
    logic [sba_pkg::DIVIDEND_W-1:0] r;
    logic [sba_pkg::Q_W-1:0]        q;
    sba_pkg::div_step_t             st;
    for (int k = 0; k < sba_pkg::DIV_STAGES; k++) begin
      r = rem[k];
      q = quo[k];
      for (int j = 0; j < sba_pkg::BITS_PER_STAGE; j++) begin
        st = sba_pkg::div_step(r, divisor,
               sba_pkg::SHIFT_W'(sba_pkg::Q_W - 1 - k * sba_pkg::BITS_PER_STAGE - j));
        r  = st.rem;
        // shift quotient bits in from the top down
        q  = {q[sba_pkg::Q_W-2:0], st.qbit};
      end
      rem_next[k] = r;
      quo_next[k] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < sba_pkg::DIV_STAGES; k++) begin
        tag[k] <= '0;
      end
      out_tag <= '0;
    end else if (en) begin
      tag[0] <= in_tag;
      for (int k = 1; k < sba_pkg::DIV_STAGES; k++) begin
        tag[k] <= tag[k-1];
      end
      out_tag <= tag[sba_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dividend;
      quo[0] <= '0;
      for (int k = 1; k < sba_pkg::DIV_STAGES; k++) begin
        rem[k] <= rem_next[k-1];
        quo[k] <= quo_next[k-1];
      end
      quotient <= quo_next[sba_pkg::DIV_STAGES-1];
    end
  end

endmodule
